// ===== sv/syf_pkg.sv =====
// Package: shared types, widths and constants for square yaw from four corners.
package syf_pkg;

  localparam int CW          = 24;
  localparam int AW          = 16;
  localparam int PRESHIFT    = 20;
  localparam int VW          = CW + 23;
  localparam int RW          = 34;
  localparam int SW          = 36;
  localparam int VW2         = SW + 22;
  localparam int TAB_LEN     = 24;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic signed [RW-1:0] COS_START = RW'(652032874);

  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  localparam logic [31:0] NOMINAL [4] = '{
    32'h0000_0000, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000
  };

  typedef struct packed {
    logic signed [CW-1:0] corner0_x;
    logic signed [CW-1:0] corner0_y;
    logic signed [CW-1:0] corner1_x;
    logic signed [CW-1:0] corner1_y;
    logic signed [CW-1:0] corner2_x;
    logic signed [CW-1:0] corner2_y;
    logic signed [CW-1:0] corner3_x;
    logic signed [CW-1:0] corner3_y;
  } corners_t;

  typedef struct packed {
    logic signed [AW-1:0] yaw_full_turn;
    logic [AW-3:0]        yaw_quarter;
    logic                 no_direction;
  } yaw_t;

endpackage

// ===== sv/square_yaw_from_four_corners_top.sv =====
// Top level: square yaw from four corners, fully pipelined.
// Takes one transaction per cycle while the output is not stalled and returns
// one per transaction. The stages in order: an input stage, the edge-angle
// vectoring CORDIC, a rotation prep stage, the cos/sin rotation CORDIC, a sum
// stage, a prep stage, the yaw vectoring CORDIC and the output register. Every
// stage has its own valid bit, so bubbles close up when the output stalls.
module square_yaw_from_four_corners_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              corners_valid,
  output logic              corners_ready,
  input  syf_pkg::corners_t corners,
  output logic              yaw_valid,
  input  logic              yaw_ready,
  output syf_pkg::yaw_t     yaw
);
  import syf_pkg::*;

  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];

  // stage A: edge vectors, prescaled and pre-rotated
  logic                 a_valid, rdy_a;
  logic signed [VW-1:0] a_x [4];
  logic signed [VW-1:0] a_y [4];
  logic [31:0]          a_z [4];
  logic [3:0]           a_zero;
  logic signed [VW-1:0] a_x_next [4];
  logic signed [VW-1:0] a_y_next [4];
  logic [31:0]          a_z_next [4];
  logic [3:0]           a_zero_next;

  logic        ev_in_ready, ev_valid;
  logic [31:0] ev_z [4];
  logic [3:0]  ev_zero;

  // stage B: edge angle less nominal, folded to the right half plane
  logic               b_valid, rdy_b;
  logic signed [32:0] b_z [4];
  logic [3:0]         b_flip;
  logic signed [32:0] b_z_next [4];
  logic [3:0]         b_flip_next;

  logic                 rot_in_ready, rv_valid;
  logic signed [RW-1:0] rv_x [4];
  logic signed [RW-1:0] rv_y [4];
  logic [3:0]           rv_flip;

  // stage C: sums
  logic                 c_valid, rdy_c;
  logic signed [SW-1:0] c_sum_c, c_sum_s;
  logic signed [SW-1:0] c_sum_c_next, c_sum_s_next;

  // stage D: yaw vector prep
  logic                  d_valid, rdy_d;
  logic signed [VW2-1:0] d_x [1];
  logic signed [VW2-1:0] d_y [1];
  logic [31:0]           d_z [1];
  logic                  d_nodir;
  logic signed [VW2-1:0] cx_w, cy_w;

  logic        fv_in_ready, fv_valid;
  logic [31:0] fv_z [1];
  logic        fv_nodir;

  logic        rdy_e;
  logic [31:0] yaw_round;

  assign px[0] = corners.corner0_x;
  assign py[0] = corners.corner0_y;
  assign px[1] = corners.corner1_x;
  assign py[1] = corners.corner1_y;
  assign px[2] = corners.corner2_x;
  assign py[2] = corners.corner2_y;
  assign px[3] = corners.corner3_x;
  assign py[3] = corners.corner3_y;

  always_comb begin
    logic signed [CW:0]   dx, dy;
    logic signed [VW-1:0] dxw, dyw;
    for (int l = 0; l < 4; l++) begin
      dx = (CW+1)'(px[(l+1)%4]) - (CW+1)'(px[l]);
      dy = (CW+1)'(py[(l+1)%4]) - (CW+1)'(py[l]);
      dxw = VW'(dx) <<< PRESHIFT;
      dyw = VW'(dy) <<< PRESHIFT;
      a_zero_next[l] = (dx == '0) && (dy == '0);
      if (dx[CW]) begin
        a_x_next[l] = -dxw;
        a_y_next[l] = -dyw;
        a_z_next[l] = HALF_TURN;
      end else begin
        a_x_next[l] = dxw;
        a_y_next[l] = dyw;
        a_z_next[l] = '0;
      end
    end
  end

  assign rdy_a         = !a_valid || ev_in_ready;
  assign corners_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (rdy_a) begin
      a_valid <= corners_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_x    <= a_x_next;
      a_y    <= a_y_next;
      a_z    <= a_z_next;
      a_zero <= a_zero_next;
    end
  end

  syf_vec_cordic #(
    .W(VW), .LANES(4), .STEPS(CORDIC_STEPS), .TW(4)
  ) u_edge_vec (
    .clk(clk), .rst(rst),
    .in_valid(a_valid), .in_ready(ev_in_ready),
    .x_in(a_x), .y_in(a_y), .z_in(a_z), .tag_in(a_zero),
    .out_valid(ev_valid), .out_ready(rdy_b),
    .z_out(ev_z), .tag_out(ev_zero)
  );

  always_comb begin
    logic [31:0] e, ep, a;
    for (int l = 0; l < 4; l++) begin
      e  = (ev_zero[l] ? 32'h0 : ev_z[l]) - NOMINAL[l];
      ep = e + QUARTER_TURN;
      b_flip_next[l] = ep[31];
      a  = ep[31] ? (e + HALF_TURN) : e;
      b_z_next[l] = signed'({a[31], a});
    end
  end

  assign rdy_b = !b_valid || rot_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (rdy_b) begin
      b_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      b_z    <= b_z_next;
      b_flip <= b_flip_next;
    end
  end

  syf_rot_cordic #(
    .W(RW), .LANES(4), .STEPS(CORDIC_STEPS), .TW(4)
  ) u_edge_rot (
    .clk(clk), .rst(rst),
    .in_valid(b_valid), .in_ready(rot_in_ready),
    .z_in(b_z), .tag_in(b_flip),
    .out_valid(rv_valid), .out_ready(rdy_c),
    .x_out(rv_x), .y_out(rv_y), .tag_out(rv_flip)
  );

  always_comb begin
    c_sum_c_next = '0;
    c_sum_s_next = '0;
    for (int l = 0; l < 4; l++) begin
      if (rv_flip[l]) begin
        c_sum_c_next = c_sum_c_next - SW'(rv_x[l]);
        c_sum_s_next = c_sum_s_next - SW'(rv_y[l]);
      end else begin
        c_sum_c_next = c_sum_c_next + SW'(rv_x[l]);
        c_sum_s_next = c_sum_s_next + SW'(rv_y[l]);
      end
    end
  end

  assign rdy_c = !c_valid || rdy_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (rdy_c) begin
      c_valid <= rv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      c_sum_c <= c_sum_c_next;
      c_sum_s <= c_sum_s_next;
    end
  end

  assign cx_w  = VW2'(c_sum_c) <<< PRESHIFT;
  assign cy_w  = VW2'(c_sum_s) <<< PRESHIFT;
  assign rdy_d = !d_valid || fv_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (rdy_d) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      d_nodir <= (c_sum_c == '0) && (c_sum_s == '0);
      if (c_sum_c[SW-1]) begin
        d_x[0] <= -cx_w;
        d_y[0] <= -cy_w;
        d_z[0] <= HALF_TURN;
      end else begin
        d_x[0] <= cx_w;
        d_y[0] <= cy_w;
        d_z[0] <= '0;
      end
    end
  end

  syf_vec_cordic #(
    .W(VW2), .LANES(1), .STEPS(CORDIC_STEPS), .TW(1)
  ) u_yaw_vec (
    .clk(clk), .rst(rst),
    .in_valid(d_valid), .in_ready(fv_in_ready),
    .x_in(d_x), .y_in(d_y), .z_in(d_z), .tag_in(d_nodir),
    .out_valid(fv_valid), .out_ready(rdy_e),
    .z_out(fv_z), .tag_out(fv_nodir)
  );

  // round half up to AW bits, wrapping modulo a turn
  assign yaw_round = fv_z[0] + (32'h1 << (31 - AW));
  assign rdy_e     = !yaw_valid || yaw_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_valid <= 1'b0;
    end else if (rdy_e) begin
      yaw_valid <= fv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e) begin
      if (fv_nodir) begin
        yaw.yaw_full_turn <= '0;
        yaw.yaw_quarter   <= '0;
        yaw.no_direction  <= 1'b1;
      end else begin
        yaw.yaw_full_turn <= signed'(yaw_round[31 -: AW]);
        yaw.yaw_quarter   <= yaw_round[31-2 -: AW-2];
        yaw.no_direction  <= 1'b0;
      end
    end
  end

  a_nodir_zero: assert property (@(posedge clk) disable iff (rst)
    yaw_valid && yaw.no_direction |-> yaw.yaw_full_turn == '0)
    else $error("no-direction result with nonzero yaw");

  a_quarter_bits: assert property (@(posedge clk) disable iff (rst)
    yaw_valid |-> yaw.yaw_quarter == yaw.yaw_full_turn[AW-3:0])
    else $error("quarter yaw does not match full yaw");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !yaw_valid |-> corners_ready)
    else $error("pipeline blocks input with empty output");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !yaw_valid)
    else $error("output valid right after reset");

endmodule

// ===== sv/syf_vec_cordic.sv =====
// Pipelined vectoring CORDIC: one register stage per iteration, multi-lane.
module syf_vec_cordic #(
  parameter int W     = 47,
  parameter int LANES = 4,
  parameter int STEPS = 16,
  parameter int TW    = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [W-1:0] x_in [LANES],
  input  logic signed [W-1:0] y_in [LANES],
  input  logic [31:0]         z_in [LANES],
  input  logic [TW-1:0]       tag_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         z_out [LANES],
  output logic [TW-1:0]       tag_out
);
  import syf_pkg::*;

  logic [STEPS-1:0]   v;
  logic [STEPS-1:0]   v_src;
  logic [STEPS-1:0]   rdy;
  logic signed [W-1:0] xr [STEPS][LANES];
  logic signed [W-1:0] yr [STEPS][LANES];
  logic [31:0]         zr [STEPS][LANES];
  logic [TW-1:0]       tr [STEPS];
  logic signed [W-1:0] xs [STEPS][LANES];
  logic signed [W-1:0] ys [STEPS][LANES];
  logic [31:0]         zs [STEPS][LANES];
  logic [TW-1:0]       ts [STEPS];

  assign v_src = {v[STEPS-2:0], in_valid};

  always_comb begin
    rdy[STEPS-1] = !v[STEPS-1] || out_ready;
    for (int s = STEPS - 2; s >= 0; s--) begin
      rdy[s] = !v[s] || rdy[s+1];
    end
  end

  always_comb begin
    xs[0] = x_in;
    ys[0] = y_in;
    zs[0] = z_in;
    ts[0] = tag_in;
    for (int s = 1; s < STEPS; s++) begin
      xs[s] = xr[s-1];
      ys[s] = yr[s-1];
      zs[s] = zr[s-1];
      ts[s] = tr[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < STEPS; s++) begin
        if (rdy[s]) begin
          v[s] <= v_src[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STEPS; s++) begin
      if (rdy[s]) begin
        tr[s] <= ts[s];
        for (int l = 0; l < LANES; l++) begin
          if (!ys[s][l][W-1]) begin
            xr[s][l] <= xs[s][l] + (ys[s][l] >>> s);
            yr[s][l] <= ys[s][l] - (xs[s][l] >>> s);
            zr[s][l] <= zs[s][l] + ATAN_TAB[s];
          end else begin
            xr[s][l] <= xs[s][l] - (ys[s][l] >>> s);
            yr[s][l] <= ys[s][l] + (xs[s][l] >>> s);
            zr[s][l] <= zs[s][l] - ATAN_TAB[s];
          end
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[STEPS-1];
  assign z_out     = zr[STEPS-1];
  assign tag_out   = tr[STEPS-1];

endmodule

// ===== sv/syf_rot_cordic.sv =====
// Pipelined rotation CORDIC for cosine and sine, one register stage per iteration.
module syf_rot_cordic #(
  parameter int W     = 34,
  parameter int LANES = 4,
  parameter int STEPS = 16,
  parameter int TW    = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [32:0]  z_in [LANES],
  input  logic [TW-1:0]       tag_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] x_out [LANES],
  output logic signed [W-1:0] y_out [LANES],
  output logic [TW-1:0]       tag_out
);
  import syf_pkg::*;

  logic [STEPS-1:0]    v;
  logic [STEPS-1:0]    v_src;
  logic [STEPS-1:0]    rdy;
  logic signed [W-1:0] xr [STEPS][LANES];
  logic signed [W-1:0] yr [STEPS][LANES];
  logic signed [32:0]  zr [STEPS][LANES];
  logic [TW-1:0]       tr [STEPS];
  logic signed [W-1:0] xs [STEPS][LANES];
  logic signed [W-1:0] ys [STEPS][LANES];
  logic signed [32:0]  zs [STEPS][LANES];
  logic [TW-1:0]       ts [STEPS];

  assign v_src = {v[STEPS-2:0], in_valid};

  always_comb begin
    rdy[STEPS-1] = !v[STEPS-1] || out_ready;
    for (int s = STEPS - 2; s >= 0; s--) begin
      rdy[s] = !v[s] || rdy[s+1];
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      xs[0][l] = W'(COS_START);
      ys[0][l] = '0;
    end
    zs[0] = z_in;
    ts[0] = tag_in;
    for (int s = 1; s < STEPS; s++) begin
      xs[s] = xr[s-1];
      ys[s] = yr[s-1];
      zs[s] = zr[s-1];
      ts[s] = tr[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < STEPS; s++) begin
        if (rdy[s]) begin
          v[s] <= v_src[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STEPS; s++) begin
      if (rdy[s]) begin
        tr[s] <= ts[s];
        for (int l = 0; l < LANES; l++) begin
          if (!zs[s][l][32]) begin
            xr[s][l] <= xs[s][l] - (ys[s][l] >>> s);
            yr[s][l] <= ys[s][l] + (xs[s][l] >>> s);
            zr[s][l] <= zs[s][l] - signed'({1'b0, ATAN_TAB[s]});
          end else begin
            xr[s][l] <= xs[s][l] + (ys[s][l] >>> s);
            yr[s][l] <= ys[s][l] - (xs[s][l] >>> s);
            zr[s][l] <= zs[s][l] + signed'({1'b0, ATAN_TAB[s]});
          end
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[STEPS-1];
  assign x_out     = xr[STEPS-1];
  assign y_out     = yr[STEPS-1];
  assign tag_out   = tr[STEPS-1];

endmodule
